@@ hdl/nmp_pkg.sv @@
// Shared types, constants, row table and arithmetic helpers for the multipole prefactor block.
`timescale 1ns / 1ps
package nmp_pkg;

  localparam int TOTAL_ROWS = 35;
  localparam int MODE_W     = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MASS_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIDAL_MODE = 2'd1;

  localparam logic signed [31:0] ONE30    = 32'sh4000_0000;
  localparam logic [30:0]        NU_RESET = 31'h4000_0000;
  localparam logic [63:0]        PI_Q60   = 64'h3243_F6A8_885A_308D;

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] orbital_frequency;
    logic [31:0] orbital_phase;
  } nmp_in_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode_index;
    logic signed [31:0] amplitude;
    logic [31:0]        phase;
    logic               last_mode;
  } nmp_out_t;

  // Powers of v for one item: slot k holds v^k, slot 0 holds v^8
  typedef struct packed {
    logic [7:0][31:0] v;
    logic [31:0]      phi;
  } nmp_rec_t;

  typedef struct packed {
    logic signed [31:0] p2;
    logic signed [31:0] p3;
    logic signed [31:0] p4;
    logic signed [31:0] p5;
    logic signed [31:0] p6;
    logic signed [31:0] p7;
  } nmp_poly_t;

  // Signed product scaled by 2^-30, rounded half away from zero
  function automatic logic signed [33:0] mulq30(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
    logic        neg;
    logic [32:0] ua;
    logic [32:0] ub;
    logic [65:0] prod;
    logic [33:0] mag;
    neg  = a[32] ^ b[32];
    ua   = a[32] ? 33'(-a) : 33'(a);
    ub   = b[32] ? 33'(-b) : 33'(b);
    prod = 66'(ua) * 66'(ub) + (66'd1 << 29);
    mag  = prod[63:30];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Integer square root, used at elaboration for the coefficient table
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Phase multiplier m per row
  localparam logic [3:0] ROW_M [TOTAL_ROWS] = '{
    4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd1, 4'd2, 4'd3, 4'd4, 4'd1,
    4'd2, 4'd3, 4'd4, 4'd5, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd1, 4'd2, 4'd3,
    4'd4, 4'd5, 4'd6, 4'd7, 4'd8
  };

  // Phase offset in quarter turns
  localparam logic [1:0] ROW_QUARTER [TOTAL_ROWS] = '{
    2'd3, 2'd2, 2'd3, 2'd0, 2'd1, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1,
    2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  // Mass polynomial select; code 0 means a zero polynomial
  localparam logic [2:0] ROW_POLY [TOTAL_ROWS] = '{
    3'd2, 3'd1, 3'd2, 3'd3, 3'd2, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd5, 3'd4, 3'd5, 3'd4, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6, 3'd5,
    3'd6, 3'd7, 3'd6, 3'd7, 3'd6, 3'd7, 3'd6, 3'd7, 3'd2, 3'd3,
    3'd4, 3'd5, 3'd6, 3'd7, 3'd0
  };

  // Power of v; code 0 selects v^8
  localparam logic [2:0] ROW_VPOW [TOTAL_ROWS] = '{
    3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5, 3'd4, 3'd5,
    3'd6, 3'd5, 3'd6, 3'd5, 3'd7, 3'd6, 3'd7, 3'd6, 3'd7, 3'd6,
    3'd7, 3'd0, 3'd7, 3'd0, 3'd7, 3'd0, 3'd7, 3'd0, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2
  };

  // c*pi/d in Q4.60
  localparam logic [63:0] COEF_X [TOTAL_ROWS] = '{
    (PI_Q60 / 64'd5) * 64'd1 + ((PI_Q60 % 64'd5) * 64'd1) / 64'd5,
    (PI_Q60 / 64'd5) * 64'd1 + ((PI_Q60 % 64'd5) * 64'd1) / 64'd5,
    (PI_Q60 / 64'd35) * 64'd2 + ((PI_Q60 % 64'd35) * 64'd2) / 64'd35,
    (PI_Q60 / 64'd7) * 64'd1 + ((PI_Q60 % 64'd7) * 64'd1) / 64'd7,
    (PI_Q60 / 64'd7) * 64'd6 + ((PI_Q60 % 64'd7) * 64'd6) / 64'd7,
    (PI_Q60 / 64'd1) * 64'd2 + ((PI_Q60 % 64'd1) * 64'd2) / 64'd1,
    (PI_Q60 / 64'd1) * 64'd1 + ((PI_Q60 % 64'd1) * 64'd1) / 64'd1,
    (PI_Q60 / 64'd7) * 64'd2 + ((PI_Q60 % 64'd7) * 64'd2) / 64'd7,
    (PI_Q60 / 64'd7) * 64'd1 + ((PI_Q60 % 64'd7) * 64'd1) / 64'd7,
    (PI_Q60 / 64'd77) * 64'd1 + ((PI_Q60 % 64'd77) * 64'd1) / 64'd77,
    (PI_Q60 / 64'd11) * 64'd1 + ((PI_Q60 % 64'd11) * 64'd1) / 64'd11,
    (PI_Q60 / 64'd22) * 64'd3 + ((PI_Q60 % 64'd22) * 64'd3) / 64'd22,
    (PI_Q60 / 64'd33) * 64'd1 + ((PI_Q60 % 64'd33) * 64'd1) / 64'd33,
    (PI_Q60 / 64'd66) * 64'd5 + ((PI_Q60 % 64'd66) * 64'd5) / 64'd66,
    (PI_Q60 / 64'd65) * 64'd2 + ((PI_Q60 % 64'd65) * 64'd2) / 64'd65,
    (PI_Q60 / 64'd13) * 64'd1 + ((PI_Q60 % 64'd13) * 64'd1) / 64'd13,
    (PI_Q60 / 64'd13) * 64'd1 + ((PI_Q60 % 64'd13) * 64'd1) / 64'd13,
    (PI_Q60 / 64'd195) * 64'd2 + ((PI_Q60 % 64'd195) * 64'd2) / 64'd195,
    (PI_Q60 / 64'd429) * 64'd5 + ((PI_Q60 % 64'd429) * 64'd5) / 64'd429,
    (PI_Q60 / 64'd715) * 64'd1 + ((PI_Q60 % 64'd715) * 64'd1) / 64'd715,
    (PI_Q60 / 64'd10) * 64'd1 + ((PI_Q60 % 64'd10) * 64'd1) / 64'd10,
    (PI_Q60 / 64'd15) * 64'd1 + ((PI_Q60 % 64'd15) * 64'd1) / 64'd15,
    (PI_Q60 / 64'd10) * 64'd3 + ((PI_Q60 % 64'd10) * 64'd3) / 64'd10,
    (PI_Q60 / 64'd165) * 64'd2 + ((PI_Q60 % 64'd165) * 64'd2) / 64'd165,
    (PI_Q60 / 64'd66) * 64'd5 + ((PI_Q60 % 64'd66) * 64'd5) / 64'd66,
    (PI_Q60 / 64'd715) * 64'd3 + ((PI_Q60 % 64'd715) * 64'd3) / 64'd715,
    (PI_Q60 / 64'd4290) * 64'd7 + ((PI_Q60 % 64'd4290) * 64'd7) / 64'd4290,
    (PI_Q60 / 64'd17017) * 64'd2 + ((PI_Q60 % 64'd17017) * 64'd2) / 64'd17017,
    64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
  };

  // Coefficient (a/b)*sqrt(c*pi/d) in Q.28, rounded
  localparam logic [31:0] COEF_Q28 [TOTAL_ROWS] = '{
    32'((64'd8 * isqrt64(COEF_X[0]) + 64'd6) / 64'd12),
    32'((64'd8 * isqrt64(COEF_X[1]) + 64'd2) / 64'd4),
    32'((64'd1 * isqrt64(COEF_X[2]) + 64'd6) / 64'd12),
    32'((64'd8 * isqrt64(COEF_X[3]) + 64'd6) / 64'd12),
    32'((64'd3 * isqrt64(COEF_X[4]) + 64'd2) / 64'd4),
    32'((64'd1 * isqrt64(COEF_X[5]) + 64'd210) / 64'd420),
    32'((64'd8 * isqrt64(COEF_X[6]) + 64'd126) / 64'd252),
    32'((64'd9 * isqrt64(COEF_X[7]) + 64'd10) / 64'd20),
    32'((64'd64 * isqrt64(COEF_X[8]) + 64'd18) / 64'd36),
    32'((64'd1 * isqrt64(COEF_X[9]) + 64'd360) / 64'd720),
    32'((64'd16 * isqrt64(COEF_X[10]) + 64'd270) / 64'd540),
    32'((64'd9 * isqrt64(COEF_X[11]) + 64'd40) / 64'd80),
    32'((64'd256 * isqrt64(COEF_X[12]) + 64'd90) / 64'd180),
    32'((64'd125 * isqrt64(COEF_X[13]) + 64'd24) / 64'd48),
    32'((64'd1 * isqrt64(COEF_X[14]) + 64'd4158) / 64'd8316),
    32'((64'd16 * isqrt64(COEF_X[15]) + 64'd2970) / 64'd5940),
    32'((64'd81 * isqrt64(COEF_X[16]) + 64'd770) / 64'd1540),
    32'((64'd1024 * isqrt64(COEF_X[17]) + 64'd990) / 64'd1980),
    32'((64'd625 * isqrt64(COEF_X[18]) + 64'd126) / 64'd252),
    32'((64'd432 * isqrt64(COEF_X[19]) + 64'd10) / 64'd20),
    32'((64'd1 * isqrt64(COEF_X[20]) + 64'd216216) / 64'd432432),
    32'((64'd8 * isqrt64(COEF_X[21]) + 64'd6006) / 64'd12012),
    32'((64'd243 * isqrt64(COEF_X[22]) + 64'd40040) / 64'd80080),
    32'((64'd1024 * isqrt64(COEF_X[23]) + 64'd2730) / 64'd5460),
    32'((64'd3125 * isqrt64(COEF_X[24]) + 64'd6552) / 64'd13104),
    32'((64'd648 * isqrt64(COEF_X[25]) + 64'd70) / 64'd140),
    32'((64'd16807 * isqrt64(COEF_X[26]) + 64'd360) / 64'd720),
    32'((64'd131072 * isqrt64(COEF_X[27]) + 64'd630) / 64'd1260),
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

endpackage

@@ hdl/nmp_mass.sv @@
// Configuration registers and iterative evaluation of the mass polynomials.
`timescale 1ns / 1ps
module nmp_mass (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [nmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           busy,
  output nmp_pkg::nmp_poly_t             poly
);
  import nmp_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_NU2, M_NU3, M_SQRT, M_P4, M_P6} mstate_t;

  mstate_t            state_r, state_nxt;
  logic [30:0]        mass_ratio_r, mass_ratio_nxt;
  logic               tidal_r, tidal_nxt;
  logic [30:0]        nu2_r, nu2_nxt;
  logic [30:0]        nu3_r, nu3_nxt;
  logic [63:0]        sq_x_r, sq_x_nxt;
  logic [63:0]        sq_q_r, sq_q_nxt;
  logic [63:0]        sq_b_r, sq_b_nxt;
  logic [4:0]         sq_cnt_r, sq_cnt_nxt;
  logic signed [31:0] p3_r, p3_nxt, p4_r, p4_nxt, p5_r, p5_nxt;
  logic signed [31:0] p6_r, p6_nxt, p7_r, p7_nxt;

  logic [29:0]        nu;
  logic signed [32:0] t_w;
  logic [30:0]        t_c;
  logic signed [35:0] nu_e, nu2_e, nu3_e, one_e;
  logic signed [35:0] a4_e, a6_e;
  logic signed [32:0] mul_a, mul_b;
  logic signed [33:0] mul_res;
  logic [63:0]        sq_sum;
  logic [30:0]        s_w;

  // Round nu to Q0.30
  assign nu    = 30'((33'(mass_ratio_r) + 33'd2) >> 2);
  assign nu_e  = $signed({6'b0, nu});
  assign nu2_e = $signed({5'b0, nu2_r});
  assign nu3_e = $signed({5'b0, nu3_r});
  assign one_e = 36'(ONE30);
  assign s_w   = sq_q_r[30:0];

  // Clamp 1-4nu at zero
  assign t_w = 33'sh0_4000_0000 - $signed({1'b0, nu, 2'b00});
  assign t_c = t_w[32] ? 31'd0 : t_w[30:0];

  assign a4_e = $signed({5'b0, nu, 1'b0}) - one_e;
  assign a6_e = one_e - 36'sd4 * nu_e + 36'sd3 * nu2_e;

  // Share one multiplier across the polynomial steps
  always_comb begin
    case (state_r)
      M_NU2:   begin mul_a = 33'(nu_e);  mul_b = 33'(nu_e); end
      M_NU3:   begin mul_a = 33'(nu2_e); mul_b = 33'(nu_e); end
      M_P4:    begin mul_a = 33'(a4_e);  mul_b = $signed({2'b0, s_w}); end
      M_P6:    begin mul_a = 33'(a6_e);  mul_b = $signed({2'b0, s_w}); end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end
  assign mul_res = mulq30(mul_a, mul_b);
  assign sq_sum  = sq_q_r + sq_b_r;

  always_comb begin
    state_nxt      = state_r;
    mass_ratio_nxt = mass_ratio_r;
    tidal_nxt      = tidal_r;
    nu2_nxt        = nu2_r;
    nu3_nxt        = nu3_r;
    sq_x_nxt       = sq_x_r;
    sq_q_nxt       = sq_q_r;
    sq_b_nxt       = sq_b_r;
    sq_cnt_nxt     = sq_cnt_r;
    p3_nxt         = p3_r;
    p4_nxt         = p4_r;
    p5_nxt         = p5_r;
    p6_nxt         = p6_r;
    p7_nxt         = p7_r;
    case (state_r)
      M_NU2: begin
        nu2_nxt   = mul_res[30:0];
        state_nxt = M_NU3;
      end
      M_NU3: begin
        nu3_nxt    = mul_res[30:0];
        sq_x_nxt   = {3'b0, t_c, 30'b0};
        sq_q_nxt   = '0;
        sq_b_nxt   = 64'd1 << 62;
        sq_cnt_nxt = '0;
        state_nxt  = M_SQRT;
      end
      // One bit of the square root per cycle
      M_SQRT: begin
        if (sq_x_r >= sq_sum) begin
          sq_x_nxt = sq_x_r - sq_sum;
          sq_q_nxt = (sq_q_r >> 1) + sq_b_r;
        end else begin
          sq_q_nxt = sq_q_r >> 1;
        end
        sq_b_nxt   = sq_b_r >> 2;
        sq_cnt_nxt = sq_cnt_r + 5'd1;
        if (sq_cnt_r == 5'd31) begin
          state_nxt = M_P4;
        end
      end
      M_P4: begin
        p4_nxt    = mul_res[31:0];
        state_nxt = M_P6;
      end
      M_P6: begin
        p6_nxt    = mul_res[31:0];
        p3_nxt    = 32'(36'sd3 * nu_e - one_e);
        p5_nxt    = 32'(one_e - 36'sd5 * nu_e + 36'sd5 * nu2_e);
        p7_nxt    = 32'(36'sd7 * nu3_e - 36'sd14 * nu2_e + 36'sd7 * nu_e - one_e);
        state_nxt = M_IDLE;
      end
      default: ;
    endcase
    // Latch register writes and restart the evaluation
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MASS_RATIO: begin
          mass_ratio_nxt = cfg_data[30:0];
          state_nxt      = M_NU2;
        end
        CFG_TIDAL_MODE: begin
          tidal_nxt = cfg_data[0];
          state_nxt = M_NU2;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= M_NU2;
      mass_ratio_r <= NU_RESET;
      tidal_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mass_ratio_r <= mass_ratio_nxt;
      tidal_r      <= tidal_nxt;
      nu2_r        <= nu2_nxt;
      nu3_r        <= nu3_nxt;
      sq_x_r       <= sq_x_nxt;
      sq_q_r       <= sq_q_nxt;
      sq_b_r       <= sq_b_nxt;
      sq_cnt_r     <= sq_cnt_nxt;
      p3_r         <= p3_nxt;
      p4_r         <= p4_nxt;
      p5_r         <= p5_nxt;
      p6_r         <= p6_nxt;
      p7_r         <= p7_nxt;
    end
  end

  assign busy    = (state_r != M_IDLE);
  assign poly.p2 = tidal_r ? ONE30 : $signed({1'b0, s_w});
  assign poly.p3 = p3_r;
  assign poly.p4 = p4_r;
  assign poly.p5 = p5_r;
  assign poly.p6 = p6_r;
  assign poly.p7 = p7_r;

endmodule

@@ hdl/nmp_front.sv @@
// Input stage: accept an item and form v = r*omega and its powers up to v^8.
`timescale 1ns / 1ps
module nmp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mass_busy,
  input  logic              in_valid,
  output logic              in_ready,
  input  nmp_pkg::nmp_in_t  in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output nmp_pkg::nmp_rec_t push_data
);
  import nmp_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_V1, F_VK, F_PUSH} fstate_t;

  fstate_t     state_r, state_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] om_r, om_nxt;
  logic [31:0] phi_r, phi_nxt;
  logic [31:0] v1_r, v1_nxt;
  logic [31:0] vlast_r, vlast_nxt;
  logic [7:0][31:0] v_r, v_nxt;
  logic [3:0]  k_r, k_nxt;

  logic [31:0] mul_a, mul_b;
  logic [64:0] prod;
  logic [64:0] sum1, sumk;
  logic [31:0] v1_sat, vk_sat;

  assign mul_a = (state_r == F_V1) ? r_r  : vlast_r;
  assign mul_b = (state_r == F_V1) ? om_r : v1_r;
  assign prod  = 65'(mul_a) * 65'(mul_b);
  assign sum1  = prod + (65'd1 << 25);
  assign sumk  = prod + (65'd1 << 29);
  // Saturate v and its powers just below 4
  assign v1_sat = (|sum1[64:58]) ? 32'hFFFF_FFFF : sum1[57:26];
  assign vk_sat = (|sum1[64:62] || |sumk[64:62]) ? 32'hFFFF_FFFF : sumk[61:30];

  assign in_ready = (state_r == F_IDLE) && !mass_busy;

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    om_nxt    = om_r;
    phi_nxt   = phi_r;
    v1_nxt    = v1_r;
    vlast_nxt = vlast_r;
    v_nxt     = v_r;
    k_nxt     = k_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          r_nxt     = in_data.radius;
          om_nxt    = in_data.orbital_frequency;
          phi_nxt   = in_data.orbital_phase;
          state_nxt = F_V1;
        end
      end
      F_V1: begin
        v1_nxt    = v1_sat;
        vlast_nxt = v1_sat;
        v_nxt[1]  = v1_sat;
        k_nxt     = 4'd2;
        state_nxt = F_VK;
      end
      // Advance one power per cycle; v^8 lands in slot zero
      F_VK: begin
        v_nxt[k_r[2:0]] = vk_sat;
        vlast_nxt       = vk_sat;
        k_nxt           = k_r + 4'd1;
        if (k_r == 4'd8) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      om_r    <= om_nxt;
      phi_r   <= phi_nxt;
      v1_r    <= v1_nxt;
      vlast_r <= vlast_nxt;
      v_r     <= v_nxt;
      k_r     <= k_nxt;
    end
  end

  assign push_valid     = (state_r == F_PUSH);
  assign push_data.v    = v_r;
  assign push_data.phi  = phi_r;

endmodule

@@ hdl/nmp_queue.sv @@
// Two-entry queue that decouples the input stage from the mode sequencer.
`timescale 1ns / 1ps
module nmp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  nmp_pkg::nmp_rec_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output nmp_pkg::nmp_rec_t pop_data
);
  import nmp_pkg::*;

  nmp_rec_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rp_r];

  // Hold entries until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        mem_r[wp_r] <= push_data;
        wp_r        <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ hdl/nmp_back.sv @@
// Mode sequencer and amplitude/phase pipeline: one result item per cycle unless out_ready holds it.
`timescale 1ns / 1ps
module nmp_back #(
  parameter int NUM_MODES = 35
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nmp_pkg::nmp_poly_t poly,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  nmp_pkg::nmp_rec_t  pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nmp_pkg::nmp_out_t  out_data
);
  import nmp_pkg::*;

  localparam logic [MODE_W-1:0] LAST_IDX = MODE_W'(NUM_MODES - 1);

  nmp_rec_t          cur_r;
  logic              run_r;
  logic [MODE_W-1:0] idx_r;

  logic               s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic signed [31:0] s1_p_r;
  logic [31:0]        s1_vp_r, s1_c_r, s1_phi_r;
  logic [3:0]         s1_m_r;
  logic [1:0]         s1_q_r;
  logic [MODE_W-1:0]  s1_idx_r, s2_idx_r, s3_idx_r;
  logic               s1_last_r, s2_last_r, s3_last_r;
  logic signed [33:0] s2_x_r;
  logic [31:0]        s2_c_r, s2_ph_r, s3_ph_r;
  logic [34:0]        s3_mag_r;
  logic               s3_neg_r;
  nmp_out_t           out_r;

  logic               adv, issue, at_last, load;
  logic signed [31:0] p_sel;
  logic [32:0]        ux;
  logic [64:0]        amp_prod;
  logic signed [31:0] amp_sat;

  assign adv     = !out_v_r || out_ready;
  assign issue   = run_r && adv;
  assign at_last = (idx_r == LAST_IDX);
  assign load    = pop_valid && (!run_r || (issue && at_last));
  assign pop_ready = load;

  // Pick the mass polynomial of the current row
  always_comb begin
    case (ROW_POLY[idx_r])
      3'd1:    p_sel = ONE30;
      3'd2:    p_sel = poly.p2;
      3'd3:    p_sel = poly.p3;
      3'd4:    p_sel = poly.p4;
      3'd5:    p_sel = poly.p5;
      3'd6:    p_sel = poly.p6;
      3'd7:    p_sel = poly.p7;
      default: p_sel = '0;
    endcase
  end

  assign ux       = s2_x_r[33] ? 33'(-s2_x_r) : s2_x_r[32:0];
  assign amp_prod = 65'(ux) * 65'(s2_c_r) + (65'd1 << 29);

  // Saturate to signed Q4.28
  always_comb begin
    if (s3_neg_r) begin
      amp_sat = (s3_mag_r >= 35'h0_8000_0000) ? 32'sh8000_0000
                                              : $signed(~s3_mag_r[31:0] + 32'd1);
    end else begin
      amp_sat = (s3_mag_r > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(s3_mag_r[31:0]);
    end
  end

  // Sequence the modes of each item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        cur_r <= pop_data;
        run_r <= 1'b1;
        idx_r <= '0;
      end else if (issue && at_last) begin
        run_r <= 1'b0;
      end else if (issue) begin
        idx_r <= idx_r + MODE_W'(1);
      end
    end
  end

  // Advance the pipeline together whenever the output can move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r    <= run_r;
      s1_p_r    <= p_sel;
      s1_vp_r   <= cur_r.v[ROW_VPOW[idx_r]];
      s1_c_r    <= COEF_Q28[idx_r];
      s1_m_r    <= ROW_M[idx_r];
      s1_q_r    <= ROW_QUARTER[idx_r];
      s1_phi_r  <= cur_r.phi;
      s1_idx_r  <= idx_r;
      s1_last_r <= at_last;

      s2_v_r    <= s1_v_r;
      s2_x_r    <= mulq30({s1_p_r[31], s1_p_r}, $signed({1'b0, s1_vp_r}));
      s2_c_r    <= s1_c_r;
      s2_ph_r   <= {s1_q_r, 30'b0} - 32'(36'(s1_m_r) * 36'(s1_phi_r));
      s2_idx_r  <= s1_idx_r;
      s2_last_r <= s1_last_r;

      s3_v_r    <= s2_v_r;
      s3_mag_r  <= amp_prod[64:30];
      s3_neg_r  <= s2_x_r[33];
      s3_ph_r   <= s2_ph_r;
      s3_idx_r  <= s2_idx_r;
      s3_last_r <= s2_last_r;

      out_v_r            <= s3_v_r;
      out_r.mode_index   <= s3_idx_r;
      out_r.amplitude    <= amp_sat;
      out_r.phase        <= s3_ph_r;
      out_r.last_mode    <= s3_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ hdl/newtonian_multipole_prefactors.sv @@
// Top level of the Newtonian multipole prefactor block.
`timescale 1ns / 1ps
// Usage:
// - Input channel (in_valid/in_ready/in_data) takes one orbit sample: radius,
//   orbital frequency and orbital phase.
// - Result channel (out_valid/out_ready/out_data) returns NUM_MODES items per
//   sample, mode_index 0 upward, last_mode set on the final one.
// - Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   mass_ratio (index 0) and tidal_mode (index 1); cfg_ready is always high.
// - The sample rate is set by the mode sequencer, which issues one mode per
//   cycle unless out_ready holds the result pipeline; the input stage runs
//   ahead into a two-entry queue.
// - After reset and after each write to mass_ratio or tidal_mode the mass
//   polynomials are re-evaluated, with a bit-serial square root;
//   in_ready stays low meanwhile.
// - When out_ready is low the result pipeline holds; the queue and the input
//   stage keep working until the queue fills.
module newtonian_multipole_prefactors #(
  parameter int NUM_MODES = 35
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  nmp_pkg::nmp_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nmp_pkg::nmp_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import nmp_pkg::*;

  nmp_poly_t poly;
  nmp_rec_t  push_data, pop_data;
  logic      mass_busy, push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  nmp_mass u_mass (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (mass_busy),
    .poly      (poly)
  );

  nmp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .mass_busy  (mass_busy),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  nmp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nmp_back #(.NUM_MODES(NUM_MODES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .poly      (poly),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/nmp_checker.sv @@
// Port-level assertions for the multipole prefactor block and their binding.
`timescale 1ns / 1ps
module nmp_checker #(
  parameter int NUM_MODES = 35
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input nmp_pkg::nmp_out_t out_data
);
  import nmp_pkg::*;

  localparam logic [MODE_W-1:0] LAST_IDX = MODE_W'(NUM_MODES - 1);
  localparam logic [MODE_W-1:0] ZERO_IDX = MODE_W'(28);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // The run ends exactly on the last mode
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_mode == (out_data.mode_index == LAST_IDX)))
    else $error("last_mode flag does not match mode_index");

  // Mode index stays in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode_index <= LAST_IDX)
    else $error("mode_index out of range");

  // Consecutive result items of a run count up by one
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_mode ##1 out_valid |->
      out_data.mode_index == $past(out_data.mode_index) + MODE_W'(1))
    else $error("mode_index skipped within a run");

  // Upper modes carry no amplitude
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode_index >= ZERO_IDX |-> out_data.amplitude == 32'sd0)
    else $error("nonzero amplitude on a zero-amplitude mode");

endmodule

bind newtonian_multipole_prefactors nmp_checker #(.NUM_MODES(NUM_MODES)) u_nmp_checker (.*);

@@ dv/newtonian_multipole_prefactors_tb.sv @@
// Testbench for the Newtonian multipole prefactor block: predicts all modes and checks them.
`timescale 1ns / 1ps
module newtonian_multipole_prefactors_tb;
  import nmp_pkg::*;

  localparam int NMODES     = 35;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 40;
  localparam int LONG_HOLD  = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Per-mode coefficient a/b*sqrt(c*pi/d), phase multiplier, quarter offset, poly, v power
  localparam longint ROW_A [NMODES] = '{8, 8, 1, 8, 3, 1, 8, 9, 64, 1, 16, 9, 256, 125, 1, 16,
    81, 1024, 625, 432, 1, 8, 243, 1024, 3125, 648, 16807, 131072, 0, 0, 0, 0, 0, 0, 0};
  localparam longint ROW_B [NMODES] = '{3, 1, 3, 3, 1, 105, 63, 5, 9, 180, 135, 20, 45, 12,
    2079, 1485, 385, 495, 63, 5, 108108, 3003, 20020, 1365, 3276, 35, 180, 315,
    1, 1, 1, 1, 1, 1, 1};
  localparam longint ROW_C [NMODES] = '{1, 1, 2, 1, 6, 2, 1, 2, 1, 1, 1, 3, 1, 5, 2, 1, 1, 2,
    5, 1, 1, 1, 3, 2, 5, 3, 7, 2, 0, 0, 0, 0, 0, 0, 0};
  localparam longint ROW_D [NMODES] = '{5, 5, 35, 7, 7, 1, 1, 7, 7, 77, 11, 22, 33, 66, 65, 13,
    13, 195, 429, 715, 10, 15, 10, 165, 66, 715, 4290, 17017, 1, 1, 1, 1, 1, 1, 1};
  localparam int ROW_MUL [NMODES] = '{1, 2, 1, 2, 3, 1, 2, 3, 4, 1, 2, 3, 4, 5, 1, 2, 3, 4, 5,
    6, 1, 2, 3, 4, 5, 6, 7, 1, 2, 3, 4, 5, 6, 7, 8};
  localparam int ROW_QTR [NMODES] = '{3, 2, 3, 0, 1, 1, 0, 3, 2, 1, 2, 3, 0, 1, 3, 2, 1, 0, 3,
    2, 3, 0, 1, 2, 3, 0, 1, 2, 0, 0, 0, 0, 0, 0, 0};
  localparam int ROW_POLY_SEL [NMODES] = '{2, 1, 2, 3, 2, 4, 3, 4, 3, 4, 5, 4, 5, 4, 6, 5, 6,
    5, 6, 5, 6, 7, 6, 7, 6, 7, 6, 7, 1, 1, 1, 1, 1, 1, 1};
  localparam int ROW_VEXP [NMODES] = '{3, 2, 3, 4, 3, 5, 4, 5, 4, 5, 6, 5, 6, 5, 7, 6, 7, 6,
    7, 6, 7, 8, 7, 8, 7, 8, 7, 8, 2, 2, 2, 2, 2, 2, 2};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  nmp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  nmp_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  newtonian_multipole_prefactors dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nmp_out_t mode_queue[$];
  longint unsigned coef_tab [NMODES];
  logic [30:0] nu_reg = NU_RESET;
  logic tidal_reg = 1'b0;
  int errors = 0;
  bit hold_request = 0;
  bit no_gaps = 0;

  // Bitwise integer square root
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Signed product scaled by 2^-30, rounded half away from zero
  function automatic longint round_mul30(longint a, longint b);
    logic [127:0] ua, ub, prod;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    prod = (ua * ub + (128'd1 << 29)) >> 30;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  initial begin
    longint unsigned pi_q60, xval;
    pi_q60 = 64'h3243_F6A8_885A_308D;
    for (int k = 0; k < NMODES; k++) begin
      xval = (pi_q60 / ROW_D[k]) * ROW_C[k] + ((pi_q60 % ROW_D[k]) * ROW_C[k]) / ROW_D[k];
      coef_tab[k] = (ROW_A[k] * int_sqrt(xval) + 2 * ROW_B[k]) / (4 * ROW_B[k]);
    end
  end

  // Work out all modes for one orbit sample under the current mass ratio and tidal flag
  task automatic predict_modes(nmp_in_t s);
    longint nu, nu2, nu3, t, sq;
    longint poly [8];
    logic [127:0] vp [9];
    longint x;
    logic [127:0] ux, mag;
    nmp_out_t e;
    nu = (longint'(nu_reg) + 2) >>> 2;
    nu2 = round_mul30(nu, nu);
    nu3 = round_mul30(nu2, nu);
    t = (64'sd1 << 30) - 4 * nu;
    if (t < 0) t = 0;
    sq = int_sqrt(t << 30);
    poly[0] = 0;
    poly[1] = 64'sd1 << 30;
    poly[2] = tidal_reg ? (64'sd1 << 30) : sq;
    poly[3] = 3 * nu - (64'sd1 << 30);
    poly[4] = round_mul30(2 * nu - (64'sd1 << 30), sq);
    poly[5] = (64'sd1 << 30) - 5 * nu + 5 * nu2;
    poly[6] = round_mul30((64'sd1 << 30) - 4 * nu + 3 * nu2, sq);
    poly[7] = 7 * nu3 - 14 * nu2 + 7 * nu - (64'sd1 << 30);
    vp[0] = 0;
    vp[1] = (128'(s.radius) * 128'(s.orbital_frequency) + (128'd1 << 25)) >> 26;
    if (vp[1] > 128'hFFFF_FFFF) vp[1] = 128'hFFFF_FFFF;
    for (int n = 2; n <= 8; n++) begin
      vp[n] = (vp[n-1] * vp[1] + (128'd1 << 29)) >> 30;
      if (vp[n] > 128'hFFFF_FFFF) vp[n] = 128'hFFFF_FFFF;
    end
    for (int k = 0; k < NMODES; k++) begin
      x = round_mul30(poly[ROW_POLY_SEL[k]], longint'(vp[ROW_VEXP[k]][63:0]));
      ux = (x < 0) ? 128'(-x) : 128'(x);
      mag = (ux * 128'(coef_tab[k]) + (128'd1 << 29)) >> 30;
      e.mode_index = k[MODE_W-1:0];
      if (x < 0) e.amplitude = (mag >= 128'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
      else e.amplitude = (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      e.phase = (32'(ROW_QTR[k]) << 30) - 32'(ROW_MUL[k]) * s.orbital_phase;
      e.last_mode = (k == NMODES - 1);
      mode_queue.push_back(e);
    end
  endtask

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one sample, hold until accepted, then predict its modes
  task automatic send_sample(logic [31:0] radius, logic [31:0] freq, logic [31:0] phi);
    int gap;
    in_valid <= 1'b1;
    in_data <= '{radius: radius, orbital_frequency: freq, orbital_phase: phi};
    do @(posedge clk); while (!in_ready);
    predict_modes(in_data);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_sample();
    logic [31:0] r, f;
    r = $urandom();
    f = $urandom();
    // Keep most samples in a realistic orbit so v stays below saturation
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(32'h0100_0000, 32'h1E00_0000);
      f = $urandom() >> $urandom_range(2, 8);
    end
    send_sample(r, f, $urandom());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (mode_queue.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MASS_RATIO) nu_reg = value[30:0];
    else if (idx == CFG_TIDAL_MODE) tidal_reg = value[0];
    @(posedge clk);
  endtask

  // Receiver: check each accepted result, then pick the next ready level
  initial begin
    int hold;
    nmp_out_t e;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (mode_queue.size() == 0) begin
          $error("unexpected result, mode_index %0d", out_data.mode_index);
          errors++;
        end else begin
          e = mode_queue.pop_front();
          if (out_data.mode_index !== e.mode_index) begin
            $error("mode_index exp %0d got %0d", e.mode_index, out_data.mode_index); errors++;
          end
          if (out_data.amplitude !== e.amplitude) begin
            $error("amplitude exp %h got %h", e.amplitude, out_data.amplitude); errors++;
          end
          if (out_data.phase !== e.phase) begin
            $error("phase exp %h got %h", e.phase, out_data.phase); errors++;
          end
          if (out_data.last_mode !== e.last_mode) begin
            $error("last_mode exp %0b got %0b", e.last_mode, out_data.last_mode); errors++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else begin
        hold = gap_len();
        out_ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet > IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_field_extremes();
    send_sample(32'h0, 32'h0, 32'h0);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h0100_0000, 32'h0800_0000, 32'h8000_0000);
    send_sample(32'h0A00_0000, 32'h0100_0000, 32'h4000_0000);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_sample(32'h0400_0000, 32'h2000_0000, 32'h0000_0001);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'hC000_0000);
    wait_idle();
  endtask

  task automatic test_mass_settings();
    logic [31:0] nu_set [5];
    nu_set = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000 | 32'h4000_0000, 32'h2000_0000, 32'h0C00_0001};
    for (int i = 0; i < 5; i++) begin
      write_reg(CFG_MASS_RATIO, nu_set[i]);
      write_reg(CFG_TIDAL_MODE, i[0] ? 32'hFFFF_FFFE : 32'h1);
      // Spare indexes must leave both registers alone
      write_reg(CFG_SPARE_LO, $urandom());
      write_reg(CFG_SPARE_HI, $urandom());
      repeat (3) send_random_sample();
      send_sample(32'h0200_0000, 32'h1000_0000, $urandom());
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    no_gaps = 1;
    hold_request = 1;
    repeat (8) send_random_sample();
    no_gaps = 0;
    wait_idle();
  endtask

  task automatic test_pause_until_drained();
    repeat (3) send_random_sample();
    wait_idle();
    repeat (3) send_random_sample();
    wait_idle();
  endtask

  task automatic test_random_samples();
    for (int i = 0; i < 110; i++) begin
      if (i % 30 == 29) begin
        wait_idle();
        write_reg(CFG_MASS_RATIO, $urandom_range(0, 2) == 0 ? $urandom() :
                  $urandom_range(0, 32'h4000_0000));
        write_reg(CFG_TIDAL_MODE, $urandom());
      end
      no_gaps = (i >= 60 && i < 80);
      send_random_sample();
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_mass_settings();
    test_backpressure();
    test_pause_until_drained();
    test_random_samples();
    wait_idle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
